// ===== sv/xtea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and the round mixing function of the XTEA block
// cipher unit.
// ----------------------------------------------------------------------------
package xtea_pkg;

  // Cipher constants.
  localparam logic [31:0] DELTA       = 32'h9E3779B9;
  localparam int unsigned ROUND_COUNT = 32;
  // Every round is split into two half-rounds, one pipeline stage each.
  localparam int unsigned NUM_STAGES  = 2 * ROUND_COUNT;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  // Direction of one block.
  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // One block in flight, with its direction.
  typedef struct packed {
    op_e   op;
    word_t w0;
    word_t w1;
  } blk_t;

  // Shift-xor-add mixing of one word.
  function automatic word_t mix(input word_t x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage
`default_nettype wire

// ===== sv/xtea_key_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_key_regs
// Holds the four 32-bit key words written through the configuration port.
// Writes to an index past the last key word are dropped.
// ----------------------------------------------------------------------------
module xtea_key_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0]       cfg_data_i,
  output xtea_pkg::key_t                    key_o
);
  import xtea_pkg::*;

  key_t key_q;

  // Decode the register index and load the addressed key word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(KEY_WORDS))) begin
      key_q[cfg_idx_i[1:0]] <= cfg_data_i;
    end
  end

  assign key_o = key_q;

endmodule
`default_nettype wire

// ===== sv/xtea_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_round
// One half-round pipeline stage. Its round sum and key selection are fixed at
// elaboration for both directions; the direction of the word picks between
// them and decides which half of the block is updated.
// ----------------------------------------------------------------------------
module xtea_round #(
  parameter int unsigned STAGE = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  xtea_pkg::blk_t  blk_i,
  input  xtea_pkg::key_t  key_i,
  output logic            valid_o,
  output xtea_pkg::blk_t  blk_o
);
  import xtea_pkg::*;

  // Round sum seen by this half-round in each direction.
  localparam int unsigned STEP     = (STAGE + 1) / 2;
  localparam bit          EVEN     = (STAGE % 2) == 0;
  localparam logic [63:0] ENC_PROD = 64'(STEP) * 64'(DELTA);
  localparam logic [63:0] DEC_PROD = 64'(ROUND_COUNT - STEP) * 64'(DELTA);
  localparam word_t       ENC_SUM  = ENC_PROD[31:0];
  localparam word_t       DEC_SUM  = DEC_PROD[31:0];
  // Encryption uses the low sum bits on its first half and bits 12:11 on its
  // second half; decryption runs the halves in the opposite order.
  localparam logic [1:0]  ENC_KIDX = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
  localparam logic [1:0]  DEC_KIDX = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

  logic  dec;
  logic  upd_w0;
  word_t src;
  word_t dst;
  word_t rsum;
  word_t f;
  word_t res;
  blk_t  blk_d;
  blk_t  blk_q;
  logic  valid_q;

  // Mix the source half, xor the keyed sum, add or subtract into the other.
  always_comb begin
    dec    = (blk_i.op == OP_DECRYPT);
    upd_w0 = EVEN ? !dec : dec;
    src    = upd_w0 ? blk_i.w1 : blk_i.w0;
    dst    = upd_w0 ? blk_i.w0 : blk_i.w1;
    rsum   = dec ? (DEC_SUM + key_i[DEC_KIDX]) : (ENC_SUM + key_i[ENC_KIDX]);
    f      = mix(src) ^ rsum;
    res    = dec ? (dst - f) : (dst + f);
    blk_d  = blk_i;
    if (upd_w0) begin
      blk_d.w0 = res;
    end else begin
      blk_d.w1 = res;
    end
  end

  // Valid bit travels with the word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule
`default_nettype wire

// ===== sv/xtea_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_out_buf
// Two-entry output buffer: an output register plus a skid register. The
// pipeline keeps moving while one finished word waits and halts only when
// both entries are taken.
// ----------------------------------------------------------------------------
module xtea_out_buf (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  xtea_pkg::blk_t               blk_i,
  output logic                         en_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [xtea_pkg::WORD_W-1:0]  out_word0_o,
  output logic [xtea_pkg::WORD_W-1:0]  out_word1_o
);
  import xtea_pkg::*;

  logic  out_valid_q;
  logic  skid_valid_q;
  word_t out_w0_q;
  word_t out_w1_q;
  word_t skid_w0_q;
  word_t skid_w1_q;
  logic  push;
  logic  take;

  // Pipeline advances whenever the skid register is free.
  assign en_o = !skid_valid_q;
  assign push = en_o && valid_i;
  assign take = !out_valid_q || out_ready_i;

  // Control: the skid entry drains first so order is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        out_w0_q <= skid_w0_q;
        out_w1_q <= skid_w1_q;
      end else begin
        out_w0_q <= blk_i.w0;
        out_w1_q <= blk_i.w1;
      end
    end else if (push) begin
      skid_w0_q <= blk_i.w0;
      skid_w1_q <= blk_i.w1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word0_o = out_w0_q;
  assign out_word1_o = out_w1_q;

endmodule
`default_nettype wire

// ===== sv/xtea_block_cipher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted word passes 64 half-round stages (two per round) and the output
// register. Throughput: one word per cycle while the pipeline is not halted.
// The pipeline halts only when both entries of the output buffer are full.
// Reset clears all valid bits and sets the four key words to zero.
// ----------------------------------------------------------------------------
// xtea_block_cipher_unit
// XTEA 64-bit block encrypt/decrypt, 32 rounds, as an unrolled pipeline with
// the 128-bit key held in four configuration registers.
// ----------------------------------------------------------------------------
module xtea_block_cipher_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port.
  input  logic                              cfg_we_i,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0]       cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [xtea_pkg::WORD_W-1:0]       in_word0_i,
  input  logic [xtea_pkg::WORD_W-1:0]       in_word1_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [xtea_pkg::WORD_W-1:0]       out_word0_o,
  output logic [xtea_pkg::WORD_W-1:0]       out_word1_o
);
  import xtea_pkg::*;

  key_t key;
  logic en;
  logic stage_vld [NUM_STAGES+1];
  blk_t stage_blk [NUM_STAGES+1];

  // Key registers.
  xtea_key_regs u_keys (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_o      (key)
  );

  // Pipeline entry.
  assign in_ready_o      = en;
  assign stage_vld[0]    = in_valid_i;
  assign stage_blk[0].op = op_e'(operation_i);
  assign stage_blk[0].w0 = in_word0_i;
  assign stage_blk[0].w1 = in_word1_i;

  // Half-round stages.
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    xtea_round #(
      .STAGE (s)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stage_vld[s]),
      .blk_i   (stage_blk[s]),
      .key_i   (key),
      .valid_o (stage_vld[s+1]),
      .blk_o   (stage_blk[s+1])
    );
  end

  // Output buffer.
  xtea_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_vld[NUM_STAGES]),
    .blk_i       (stage_blk[NUM_STAGES]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word0_o (out_word0_o),
    .out_word1_o (out_word1_o)
  );

endmodule
`default_nettype wire

// ===== sim/xtea_block_cipher_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtea_block_cipher_unit_test
// Self-checking testbench for the XTEA block cipher unit. A scoreboard
// computes the 32-round encipher or decipher of every accepted word under the
// current key and compares each result word in order. Directed blocks cover the
// word extremes and round trips, then random phases change the key and push
// random blocks while both channels idle at random. One phase floods the input
// while the output is held off for a long stretch.
// ----------------------------------------------------------------------------
module xtea_block_cipher_unit_test;
  import xtea_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned DRAIN_CYCLES    = NUM_STAGES + 8;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned WORDS_PER_PHASE = 200;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned FLOOD_PHASE     = 2;
  localparam int unsigned LAST_CFG_IDX    = (1 << CFG_IDX_W) - 1;

  // Expected cipher results in arrival order, and the key they depend on.
  class xtea_scoreboard;
    typedef struct {
      word_t w0;
      word_t w1;
    } block_pair_t;

    word_t       key_words[KEY_WORDS];
    block_pair_t expected_blocks[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    // Writes past the last key word are dropped by the block.
    function void write_reg(int unsigned idx, word_t data);
      if (idx < KEY_WORDS) begin
        key_words[idx] = data;
      end
    endfunction

    function word_t shift_mix(word_t x);
      return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // Full 32-round encipher or decipher of one block under the held key.
    function void cipher_block(input op_e op, input word_t a_in, input word_t b_in,
                               output word_t a, output word_t b);
      word_t       s;
      int unsigned r;
      a = a_in;
      b = b_in;
      if (op == OP_ENCRYPT) begin
        s = '0;
        for (r = 0; r < ROUND_COUNT; r++) begin
          a += shift_mix(b) ^ (s + key_words[s[1:0]]);
          s += DELTA;
          b += shift_mix(a) ^ (s + key_words[s[12:11]]);
        end
      end else begin
        s = word_t'(DELTA * ROUND_COUNT);
        for (r = 0; r < ROUND_COUNT; r++) begin
          b -= shift_mix(a) ^ (s + key_words[s[12:11]]);
          s -= DELTA;
          a -= shift_mix(b) ^ (s + key_words[s[1:0]]);
        end
      end
    endfunction

    function void note_input(op_e op, word_t w0, word_t w1);
      block_pair_t blk;
      cipher_block(op, w0, w1, blk.w0, blk.w1);
      expected_blocks.push_back(blk);
    endfunction

    function void check_result(word_t w0, word_t w1);
      block_pair_t exp_blk;
      if (expected_blocks.size() == 0) begin
        $display("%0t: result word %h %h arrived with nothing outstanding", $time, w0, w1);
        errors++;
        return;
      end
      exp_blk = expected_blocks.pop_front();
      checked++;
      if (w0 !== exp_blk.w0) begin
        $display("%0t: out_word0 expected %h actual %h", $time, exp_blk.w0, w0);
        errors++;
      end
      if (w1 !== exp_blk.w1) begin
        $display("%0t: out_word1 expected %h actual %h", $time, exp_blk.w1, w1);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  word_t                cfg_data;
  logic                 in_valid;
  logic                 in_ready_o;
  op_e                  operation;
  word_t                in_word0;
  word_t                in_word1;
  logic                 out_valid_o;
  logic                 out_ready;
  word_t                out_word0_o;
  word_t                out_word1_o;

  xtea_scoreboard sb;
  bit             hold_request;
  bit             tx_steady;
  int unsigned    cycle_count;
  int unsigned    blocks_sent;
  int unsigned    keys_loaded;
  int unsigned    holds_done;

  xtea_block_cipher_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (operation),
    .in_word0_i  (in_word0),
    .in_word1_i  (in_word1),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word0_o (out_word0_o),
    .out_word1_o (out_word1_o)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Random word biased toward all-zero, all-one and single-bit patterns.
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: return word_t'($urandom);
    endcase
  endfunction

  // Load all four key words, then poke an index past them.
  task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
    word_t       kw[KEY_WORDS];
    word_t       stray_data;
    int unsigned stray_idx;
    int unsigned i;
    kw = '{k0, k1, k2, k3};
    cfg_we <= 1'b1;
    for (i = 0; i < KEY_WORDS; i++) begin
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= kw[i];
      @(posedge clk_i);
      sb.write_reg(i, kw[i]);
    end
    stray_idx  = $urandom_range(KEY_WORDS, LAST_CFG_IDX);
    stray_data = word_t'($urandom);
    cfg_idx  <= CFG_IDX_W'(stray_idx);
    cfg_data <= stray_data;
    @(posedge clk_i);
    sb.write_reg(stray_idx, stray_data);
    cfg_we <= 1'b0;
    keys_loaded++;
  endtask

  // Offer one word and hold it until the block takes it.
  task automatic send_block(input op_e op, input word_t w0, input word_t w1);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    in_word0  <= w0;
    in_word1  <= w1;
    do @(posedge clk_i); while (!in_ready_o);
    blocks_sent++;
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Both handshakes are sampled on the edge that completes them.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        sb.note_input(operation, in_word0, in_word1);
      end
      if (out_valid_o && out_ready) begin
        sb.check_result(out_word0_o, out_word1_o);
      end
    end
  end

  // Receiver: random stalls, long ready stretches, and one long hold-off.
  // A ready stretch ends early once a hold-off is requested.
  initial begin
    int unsigned rx_gap;
    int unsigned rx_run;
    int unsigned k;
    out_ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        rx_gap = pick_gap();
        if (rx_gap != 0) begin
          out_ready <= 1'b0;
          repeat (rx_gap) @(posedge clk_i);
        end
        out_ready <= 1'b1;
        rx_run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
        k = 0;
        do begin
          @(posedge clk_i);
          k++;
        end while (k < rx_run && !hold_request);
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
    $display("FAILURE");
    $finish;
  end

  // Main stimulus.
  initial begin
    word_t       dir_w0[3];
    word_t       dir_w1[3];
    word_t       ct0;
    word_t       ct1;
    word_t       w0;
    word_t       w1;
    op_e         op;
    bit          have_ct;
    int unsigned phase;
    int unsigned n;
    int unsigned i;

    sb           = new();
    hold_request = 1'b0;
    tx_steady    = 1'b0;
    blocks_sent  = 0;
    keys_loaded  = 0;
    holds_done   = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    operation <= OP_ENCRYPT;
    in_word0  <= '0;
    in_word1  <= '0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: word extremes both ways and a round trip, under three keys.
    dir_w0 = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
    dir_w1 = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: load_key('0, '0, '0, '0);
        1: load_key('1, '1, '1, '1);
        default: load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      endcase
      for (i = 0; i < 3; i++) begin
        send_block(OP_ENCRYPT, dir_w0[i], dir_w1[i]);
        send_block(OP_DECRYPT, dir_w0[i], dir_w1[i]);
      end
      sb.cipher_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, ct0, ct1);
      send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
      send_block(OP_DECRYPT, ct0, ct1);
      drain();
    end

    // Random phases, each under a fresh key.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 5)
        0: load_key(word_t'($urandom), word_t'($urandom), word_t'($urandom), word_t'($urandom));
        1: load_key('1, '1, '1, '1);
        2: load_key('0, '0, '0, '0);
        3: load_key(word_t'(1) << $urandom_range(0, 31), word_t'(1) << $urandom_range(0, 31),
                    word_t'(1) << $urandom_range(0, 31), word_t'(1) << $urandom_range(0, 31));
        default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
      endcase
      have_ct = 1'b0;
      // Flood the input while the receiver is held off, so the pipe fills.
      if (phase == FLOOD_PHASE) begin
        hold_request = 1'b1;
      end
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          tx_steady = (phase == FLOOD_PHASE && n < 150) || ($urandom_range(0, 3) == 0);
        end
        // Now and then decipher the last enciphered block to close the loop.
        if (have_ct && $urandom_range(0, 4) == 0) begin
          send_block(OP_DECRYPT, ct0, ct1);
          have_ct = 1'b0;
        end else begin
          op = op_e'($urandom_range(0, 1));
          w0 = rand_word();
          w1 = rand_word();
          send_block(op, w0, w1);
          if (op == OP_ENCRYPT) begin
            sb.cipher_block(OP_ENCRYPT, w0, w1, ct0, ct1);
            have_ct = 1'b1;
          end
        end
      end
      drain();
    end

    tx_steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d blocks in both directions under %0d key loads; %0d results checked.",
             blocks_sent, keys_loaded, sb.checked);
    $display("Output held off %0d time(s) for %0d cycles with the input flooded; %0d errors.",
             holds_done, HOLD_CYCLES, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
